### sv/fit_policy_region_allocator_defines.svh
// Assertion macros used by the allocator top module.
`ifndef FIT_POLICY_REGION_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_REGION_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define FPRA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fpra assertion failed");
`define FPRA_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("fpra assertion failed");
`else
`define FPRA_ASSERT(label, clk, rstn, prop)
`define FPRA_ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif
`endif

### sv/fpra_pkg.sv
package fpra_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam logic [31:0] INIT_REGION_SIZE = 32'hFFFF_FFFF;
    localparam logic [31:0] INIT_REGION_START = 32'd1;
    localparam logic [17:0] HEADER_BYTES = 18'd8;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_WORST = 2'd1;
    localparam logic [1:0] POLICY_BEST = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic        used;
        logic [31:0] size;
        logic [31:0] start;
    } entry_t;

    typedef struct packed {
        logic        upd_en;
        logic [31:0] upd_size;
        logic        app_en;
        entry_t      app_entry;
    } cell_wr_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

endpackage

### sv/fpra_cell.sv
module fpra_cell import fpra_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic          shift,
    input  entry_t        shift_in,
    output entry_t        shift_out,
    input  cell_wr_t      wr,
    input  logic [IW-1:0] upd_idx,
    input  logic [IW-1:0] app_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    entry_t entry_reg;
    entry_t shadow_reg;

    // Only the first descriptor has a defined value after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            if (INDEX == 0) begin
                entry_reg.used <= 1'b0;
                entry_reg.size <= INIT_REGION_SIZE;
                entry_reg.start <= INIT_REGION_START;
            end
        end else if (wr.app_en && app_idx == MY_IDX) begin
            entry_reg <= wr.app_entry;
        end else if (wr.upd_en && upd_idx == MY_IDX) begin
            entry_reg.size <= wr.upd_size;
        end
    end

    // The shadow copy moves one cell toward the head each scan cycle.
    always_ff @(posedge aclk) begin
        if (load) begin
            shadow_reg <= entry_reg;
        end else if (shift) begin
            shadow_reg <= shift_in;
        end
    end

    assign shift_out = shadow_reg;

endmodule

### sv/fit_policy_region_allocator.sv
// Channel  | Ports                                   | Direction
// s_       | s_key_length, s_value_length            | request in
// m_       | m_status, m_alloc_offset, m_alloc_size  | result out
// cfg_     | cfg_wr_en, cfg_wr_data (fit policy)     | register write
//
// Each request is accepted in the idle state, which snapshots the descriptor
// row; the scan state then shifts the snapshot past the head cell, and the
// commit state writes the result. A full table still takes the full scan.
// aresetn is synchronous; it restores one free region and the first-fit policy.
// A result waits in the output register; the next request is accepted while
// it waits, and commit stalls only if an older result is still not taken.
module fit_policy_region_allocator import fpra_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_key_length,
    input  logic [15:0] s_value_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_alloc_offset,
    output logic [17:0] m_alloc_size
);

`include "fit_policy_region_allocator_defines.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [1:0]    policy_reg;
    logic [CW-1:0] entry_count_reg;
    logic [17:0]   need_reg;
    logic          full_reg;
    logic [IW-1:0] scan_idx_reg;
    logic          found_reg;
    logic [31:0]   best_size_reg;
    logic [31:0]   best_rest_reg;
    logic [31:0]   best_start_reg;
    logic [IW-1:0] pick_reg;
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic [31:0]   m_alloc_offset_reg;
    logic [17:0]   m_alloc_size_reg;

    logic     accept;
    logic     load;
    logic     shift;
    logic     commit;
    logic     take;
    logic     cand;
    entry_t   head;
    cell_wr_t wr;
    entry_t   chain [TABLE_DEPTH+1];

    assign chain[TABLE_DEPTH] = '0;
    assign head = chain[0];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        fpra_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .INDEX       (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (load),
            .shift     (shift),
            .shift_in  (chain[g+1]),
            .shift_out (chain[g]),
            .wr        (wr),
            .upd_idx   (pick_reg),
            .app_idx   (entry_count_reg[IW-1:0])
        );
    end

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        load = 1'b0;
        shift = 1'b0;
        commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                shift = 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign accept = s_valid && s_ready;

    // Entries at or past the count are never considered.
    assign cand = ({{(CW-IW){1'b0}}, scan_idx_reg} < entry_count_reg) && !head.used
                  && ({14'd0, need_reg} <= head.size);

    always_comb begin
        case (policy_reg)
            POLICY_FIRST: take = cand && !found_reg;
            POLICY_WORST: take = cand && (!found_reg || head.size > best_size_reg);
            POLICY_BEST:  take = cand && (!found_reg || head.size < best_size_reg);
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        wr.upd_en = commit && found_reg && !full_reg;
        wr.upd_size = best_rest_reg;
        wr.app_en = commit && found_reg && !full_reg;
        wr.app_entry.used = 1'b1;
        wr.app_entry.size = {14'd0, need_reg};
        wr.app_entry.start = best_start_reg + best_rest_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            policy_reg <= POLICY_FIRST;
            entry_count_reg <= CW'(1);
            m_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                policy_reg <= cfg_wr_data;
            end
            if (wr.app_en) begin
                entry_count_reg <= entry_count_reg + CW'(1);
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                found_reg <= 1'b0;
            end else if (shift && take && !full_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            need_reg <= 18'(s_key_length) + 18'(s_value_length) + HEADER_BYTES;
            full_reg <= (entry_count_reg == FULL_COUNT);
            scan_idx_reg <= '0;
        end else if (shift) begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
        end
        if (shift && take) begin
            best_size_reg <= head.size;
            best_rest_reg <= head.size - {14'd0, need_reg};
            best_start_reg <= head.start;
            pick_reg <= scan_idx_reg;
        end
        if (commit) begin
            m_alloc_size_reg <= need_reg;
            if (full_reg) begin
                m_status_reg <= STATUS_FULL;
                m_alloc_offset_reg <= '0;
            end else if (found_reg) begin
                m_status_reg <= STATUS_OK;
                m_alloc_offset_reg <= best_start_reg + best_rest_reg;
            end else begin
                m_status_reg <= STATUS_NO_FIT;
                m_alloc_offset_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_alloc_offset = m_alloc_offset_reg;
    assign m_alloc_size = m_alloc_size_reg;

    `FPRA_ASSERT(a_count_bound, aclk, aresetn, entry_count_reg <= FULL_COUNT)
    `FPRA_ASSERT(a_fail_zero_offset, aclk, aresetn, (m_valid && m_status != STATUS_OK) |-> (m_alloc_offset == 32'd0))
    `FPRA_ASSERT_NEXT(a_count_step, aclk, aresetn, wr.app_en, entry_count_reg == $past(entry_count_reg) + CW'(1))
    `FPRA_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != S_IDLE) |-> !s_ready)

endmodule

### dv/fit_policy_region_allocator_tb.sv
`timescale 1ns / 1ps

module fit_policy_region_allocator_tb;
    import fpra_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int SETTLE_CYCLES = DEPTH + 20;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offset;
        logic [17:0] size;
    } alloc_result_t;

    // Tracks the descriptor table and predicts each allocation result.
    class alloc_scoreboard;
        logic          region_used [DEPTH];
        logic [31:0]   region_size [DEPTH];
        logic [31:0]   region_start[DEPTH];
        int            region_count;
        logic [1:0]    policy;
        alloc_result_t pending_results[$];
        int            error_count;

        function void reset_state();
            region_used[0]  = 1'b0;
            region_size[0]  = INIT_REGION_SIZE;
            region_start[0] = INIT_REGION_START;
            region_count    = 1;
            policy          = POLICY_FIRST;
            pending_results.delete();
            error_count     = 0;
        endfunction

        function void note_request(logic [15:0] key_len, logic [15:0] val_len);
            alloc_result_t res;
            logic [31:0]   need;
            logic [31:0]   rest;
            logic [31:0]   chosen_size;
            bit            found;
            bit            bad_policy;
            int            pick;
            need = 32'(key_len) + 32'(val_len) + 32'd8;
            res.status = STATUS_OK;
            res.offset = '0;
            res.size   = need[17:0];
            found = 0;
            bad_policy = 0;
            pick = 0;
            chosen_size = '0;
            if (region_count >= DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                for (int i = 0; i < region_count; i++) begin
                    if (found && policy == POLICY_FIRST)
                        break;
                    if (!region_used[i] && region_size[i] >= need) begin
                        if (policy == POLICY_FIRST) begin
                            found = 1;
                            pick = i;
                        end else if (policy == POLICY_WORST) begin
                            if (!found || region_size[i] > chosen_size) begin
                                found = 1;
                                chosen_size = region_size[i];
                                pick = i;
                            end
                        end else if (policy == POLICY_BEST) begin
                            if (!found || region_size[i] < chosen_size) begin
                                found = 1;
                                chosen_size = region_size[i];
                                pick = i;
                            end
                        end else begin
                            bad_policy = 1;
                            break;
                        end
                    end
                end
                if (!found || bad_policy) begin
                    res.status = STATUS_NO_FIT;
                end else begin
                    rest = region_size[pick] - need;
                    res.offset = region_start[pick] + rest;
                    region_size[pick] = rest;
                    region_used[region_count]  = 1'b1;
                    region_size[region_count]  = need;
                    region_start[region_count] = res.offset;
                    region_count++;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d offset %0h size %0d",
                       got.status, got.offset, got.size);
                error_count++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                error_count++;
            end
            if (got.offset !== exp.offset) begin
                $error("alloc_offset: expected %0h, actual %0h", exp.offset, got.offset);
                error_count++;
            end
            if (got.size !== exp.size) begin
                $error("alloc_size: expected %0d, actual %0d", exp.size, got.size);
                error_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_key_length = '0;
    logic [15:0] s_value_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_alloc_offset;
    logic [17:0] m_alloc_size;

    alloc_scoreboard alloc_sb = new();
    longint cycle_count = 0;
    int burst_left = 0;
    int sent_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fit_policy_region_allocator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_length   (s_key_length),
        .s_value_length (s_value_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alloc_offset (m_alloc_offset),
        .m_alloc_size   (m_alloc_size)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Both monitors sample the values present just before the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            alloc_sb.note_request(s_key_length, s_value_length);
        if (aresetn && m_valid && m_ready)
            alloc_sb.check_result('{m_status, m_alloc_offset, m_alloc_size});
    end

    // The receiver steps through stall patterns chosen by bits 11:10 of the cycle count,
    // with one mode that never stalls.
    always @(posedge aclk) begin
        case (cycle_count[11:10])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= (cycle_count % 3) != 0;
            2'd2: m_ready <= $urandom_range(0, 1);
            default: m_ready <= (cycle_count % 7) > 4;
        endcase
    end

    task automatic send_request(input logic [15:0] key_len, input logic [15:0] val_len);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_key_length <= key_len;
        s_value_length <= val_len;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent_count++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (alloc_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_policy(input logic [1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        alloc_sb.policy = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        alloc_sb.reset_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes under every policy, including the unused code.
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h5555, 16'hAAAA);
        write_policy(2'd3);
        send_request(16'h0001, 16'h0002);
        send_request(16'hFFFF, 16'hFFFF);
        write_policy(POLICY_WORST);
        send_request(16'h0000, 16'h0000);
        send_request(16'hAAAA, 16'h5555);
        send_request(16'hFFFF, 16'hFFFF);
        write_policy(POLICY_BEST);
        send_request(16'h0000, 16'h0000);
        send_request(16'h1234, 16'h0010);
        send_request(16'hFFFF, 16'hFFFF);
        write_policy(POLICY_FIRST);
        send_request(16'h0007, 16'h0000);

        // Random phases; the table fills after a few hundred allocations and
        // the rest of the run checks the full-table response.
        while (sent_count < ITEM_TARGET) begin
            write_policy(2'($urandom_range(0, 3)));
            repeat ($urandom_range(60, 200)) begin
                if (sent_count >= ITEM_TARGET)
                    break;
                if ($urandom_range(0, 9) == 0)
                    send_request($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                 $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                else
                    send_request(16'($urandom), 16'($urandom));
            end
        end

        drain();
        foreach (alloc_sb.pending_results[i]) begin
            $error("missing result: status %0d",
                   alloc_sb.pending_results[i].status);
            alloc_sb.error_count++;
        end
        if (alloc_sb.error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/fpra_pkg.sv
sv/fpra_cell.sv
sv/fit_policy_region_allocator.sv
dv/fit_policy_region_allocator_tb.sv
